// ===== rtl/core/ihpc_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser package
// Status codes, header word positions, the result record shared by the
// parser and its output queue, and the one's-complement halfword adder.
// ----------------------------------------------------------------------------
package ihpc_pkg;

	typedef enum logic [1:0] {
		STATUS_OK           = 2'd0,
		STATUS_OVERFLOW     = 2'd1,
		STATUS_BAD_VERSION  = 2'd2,
		STATUS_BAD_CHECKSUM = 2'd3
	} status_t;

	localparam logic [3:0]  IP_VERSION       = 4'd4;
	localparam logic [3:0]  MIN_IHL          = 4'd5;
	localparam logic [15:0] MIN_BUFFER_BYTES = 16'd20;

	localparam logic [3:0] WORD_NONE  = 4'd0;
	localparam logic [3:0] WORD_FLAGS = 4'd1;
	localparam logic [3:0] WORD_TTL   = 4'd2;
	localparam logic [3:0] WORD_SRC   = 4'd3;
	localparam logic [3:0] WORD_DST   = 4'd4;

	typedef struct packed {
		status_t     status;
		logic [3:0]  header_words;
		logic [7:0]  dscp_ecn;
		logic [15:0] total_length;
		logic [15:0] fragment_id;
		logic [2:0]  fragment_flags;
		logic [12:0] fragment_offset;
		logic [7:0]  time_to_live;
		logic [7:0]  protocol_number;
		logic [15:0] stored_checksum;
		logic [31:0] source_address;
		logic [31:0] dest_address;
	} result_t;

	// Adds one halfword to the running sum and folds the carry back in.
	function automatic logic [16:0] fold_add(input logic [16:0] sum, input logic [15:0] half);
		logic [17:0] s;
		s = {1'b0, sum} + {2'b00, half};
		return {1'b0, s[15:0]} + {15'd0, s[17:16]};
	endfunction

endpackage

// ===== rtl/core/ihpc_in_if.sv =====
// ----------------------------------------------------------------------------
// IPv4 header word channel
// Carries one header word per transaction with its framing information.
// ----------------------------------------------------------------------------
interface ihpc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] header_word;
	logic        first_word;
	logic [15:0] buffer_bytes;

	modport source (output valid, output header_word, output first_word,
		output buffer_bytes, input ready);
	modport sink (input valid, input header_word, input first_word,
		input buffer_bytes, output ready);
endinterface

// ===== rtl/core/ihpc_out_if.sv =====
// ----------------------------------------------------------------------------
// IPv4 header result channel
// Carries the decoded fixed header fields and the check status.
// ----------------------------------------------------------------------------
interface ihpc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  header_words;
	logic [7:0]  dscp_ecn;
	logic [15:0] total_length;
	logic [15:0] fragment_id;
	logic [2:0]  fragment_flags;
	logic [12:0] fragment_offset;
	logic [7:0]  time_to_live;
	logic [7:0]  protocol_number;
	logic [15:0] stored_checksum;
	logic [31:0] source_address;
	logic [31:0] dest_address;

	modport source (output valid, output status, output header_words, output dscp_ecn,
		output total_length, output fragment_id, output fragment_flags,
		output fragment_offset, output time_to_live, output protocol_number,
		output stored_checksum, output source_address, output dest_address,
		input ready);
	modport sink (input valid, input status, input header_words, input dscp_ecn,
		input total_length, input fragment_id, input fragment_flags,
		input fragment_offset, input time_to_live, input protocol_number,
		input stored_checksum, input source_address, input dest_address,
		output ready);
endinterface

// ===== rtl/core/ihpc_front.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser front end
// Accepts header words, captures the fixed fields, keeps the running
// checksum and classifies each header into one result record.
// ----------------------------------------------------------------------------
module ihpc_front (
	input  logic              clk,
	input  logic              arst_n,
	ihpc_in_if.sink           hdr,
	input  logic              full,
	output logic              push,
	output ihpc_pkg::result_t push_data
);
	import ihpc_pkg::*;

	logic [3:0]  word_count_q;
	logic [16:0] sum_q;
	logic [15:0] avail_q;
	logic [31:0] w0_q;
	logic [31:0] w1_q;
	logic [31:0] w2_q;
	logic [31:0] w3_q;
	logic [31:0] w4_q;

	logic        accept;
	logic [15:0] hi;
	logic [15:0] lo;
	logic [16:0] sum_first;
	logic [16:0] sum_a;
	logic [16:0] sum_b;
	logic [3:0]  ihl;
	logic [15:0] len;
	logic [3:0]  need;
	logic        short_buf;
	logic        bad_version;
	logic        bounds_err;
	logic        done;
	logic [31:0] dest;
	result_t     full_rec;

	assign hdr.ready = !full;
	assign accept    = hdr.valid && hdr.ready;
	assign hi        = hdr.header_word[31:16];
	assign lo        = hdr.header_word[15:0];

	assign sum_first = fold_add(fold_add(17'd0, hi), lo);
	assign sum_a     = fold_add(sum_q, hi);
	assign sum_b     = (word_count_q == WORD_TTL) ? sum_a : fold_add(sum_a, lo);

	assign ihl         = w0_q[27:24];
	assign len         = w0_q[15:0];
	assign need        = (ihl < MIN_IHL) ? MIN_IHL : ihl;
	assign short_buf   = hdr.buffer_bytes < MIN_BUFFER_BYTES;
	assign bad_version = hdr.header_word[31:28] != IP_VERSION;
	assign bounds_err  = (len > avail_q) || ({10'd0, ihl, 2'b00} > len) || (ihl < MIN_IHL);
	assign done        = (({1'b0, word_count_q} + 5'd1) >= {1'b0, need})
		&& (word_count_q >= WORD_DST);
	assign dest        = (word_count_q == WORD_DST) ? hdr.header_word : w4_q;

	always_comb begin
		full_rec.status          = STATUS_OK;
		full_rec.header_words    = ihl;
		full_rec.dscp_ecn        = w0_q[23:16];
		full_rec.total_length    = len;
		full_rec.fragment_id     = w1_q[31:16];
		full_rec.fragment_flags  = w1_q[15:13];
		full_rec.fragment_offset = w1_q[12:0];
		full_rec.time_to_live    = w2_q[31:24];
		full_rec.protocol_number = w2_q[23:16];
		full_rec.stored_checksum = w2_q[15:0];
		full_rec.source_address  = w3_q;
		full_rec.dest_address    = dest;
	end

	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (accept) begin
			if (hdr.first_word) begin
				if (short_buf) begin
					push             = 1'b1;
					push_data.status = STATUS_OVERFLOW;
				end else if (bad_version) begin
					push             = 1'b1;
					push_data.status = STATUS_BAD_VERSION;
				end
			end else if (word_count_q != WORD_NONE) begin
				if (word_count_q == WORD_DST && bounds_err) begin
					push             = 1'b1;
					push_data        = full_rec;
					push_data.status = STATUS_OVERFLOW;
				end else if (done) begin
					push             = 1'b1;
					push_data        = full_rec;
					push_data.status = (~sum_b[15:0] != w2_q[15:0]) ?
						STATUS_BAD_CHECKSUM : STATUS_OK;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= WORD_NONE;
			sum_q        <= '0;
		end else if (accept) begin
			if (hdr.first_word) begin
				if (short_buf || bad_version) begin
					word_count_q <= WORD_NONE;
					sum_q        <= '0;
				end else begin
					word_count_q <= WORD_FLAGS;
					sum_q        <= sum_first;
				end
			end else if (word_count_q != WORD_NONE) begin
				sum_q <= sum_b;
				if (push) begin
					word_count_q <= WORD_NONE;
				end else begin
					word_count_q <= word_count_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (hdr.first_word) begin
				avail_q <= hdr.buffer_bytes;
				if (!short_buf && !bad_version) begin
					w0_q <= hdr.header_word;
				end
			end else begin
				case (word_count_q)
					WORD_FLAGS: w1_q <= hdr.header_word;
					WORD_TTL:   w2_q <= hdr.header_word;
					WORD_SRC:   w3_q <= hdr.header_word;
					WORD_DST:   w4_q <= hdr.header_word;
					default: ;
				endcase
			end
		end
	end

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (hdr.valid && hdr.ready))
		else $error("result produced without an accepted word");

	a_close_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (word_count_q == WORD_NONE))
		else $error("header still open after its result");

	a_no_result_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !hdr.first_word && word_count_q == WORD_NONE) |-> !push)
		else $error("stray word produced a result");

endmodule

// ===== rtl/core/ihpc_queue.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser result queue
// Two-entry queue that holds result records until the sink takes them.
// ----------------------------------------------------------------------------
module ihpc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ihpc_pkg::result_t push_data,
	output logic              full,
	ihpc_out_if.source        res
);
	import ihpc_pkg::*;

	result_t    ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	result_t    head;

	assign full      = count_q == 2'd2;
	assign res.valid = count_q != 2'd0;
	assign pop       = res.valid && res.ready;
	assign head      = ent_q[rd_ptr_q];

	assign res.status          = head.status;
	assign res.header_words    = head.header_words;
	assign res.dscp_ecn        = head.dscp_ecn;
	assign res.total_length    = head.total_length;
	assign res.fragment_id     = head.fragment_id;
	assign res.fragment_flags  = head.fragment_flags;
	assign res.fragment_offset = head.fragment_offset;
	assign res.time_to_live    = head.time_to_live;
	assign res.protocol_number = head.protocol_number;
	assign res.stored_checksum = head.stored_checksum;
	assign res.source_address  = head.source_address;
	assign res.dest_address    = head.dest_address;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("result pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("queue occupancy out of range");

	a_pointer_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with occupancy");

endmodule

// ===== rtl/core/ipv4_header_parser_checker_core.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser and checksum checker
// Parses a stream of header words, verifies bounds, version and checksum,
// and delivers one result transaction per header.
//
//   channel  dir  payload
//   hdr      in   header_word[32], first_word[1], buffer_bytes[16]
//   res      out  status[2] and the decoded fixed header fields
//
// One header word is accepted every cycle except while both queue entries
// are occupied, when hdr.ready is low. A result is written into the output
// queue in the same cycle as the word that completes it and can be taken on
// the next cycle. The two-entry queue lets the front end keep accepting
// while a result waits. Reset clears the header state and empties the queue.
// ----------------------------------------------------------------------------
module ipv4_header_parser_checker_core (
	input  logic       clk,
	input  logic       arst_n,
	ihpc_in_if.sink    hdr,
	ihpc_out_if.source res
);
	import ihpc_pkg::*;

	logic    full;
	logic    push;
	result_t push_data;

	ihpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr       (hdr),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	ihpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.res       (res)
	);

endmodule

// ===== dv/tb_ipv4_header_parser_checker_core.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser and checksum checker testbench
// Sends IPv4 headers word by word: valid headers of every length, bad
// checksums, short buffers, wrong versions, bounds errors, stray words and
// aborted headers. Both channel sides idle at random. A scoreboard predicts
// the result of every header and checks each result transaction field by
// field, in order.
// ----------------------------------------------------------------------------
module tb_ipv4_header_parser_checker_core;
	import ihpc_pkg::*;

	localparam int TARGET_WORDS = 1950;
	localparam int QUIET_WORDS = 1650;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	class ipv4_result_scoreboard;
		logic [3:0]  next_index;
		logic [16:0] csum_acc;
		logic [15:0] buf_avail;
		logic [31:0] word_len;
		logic [31:0] word_frag;
		logic [31:0] word_ttl;
		logic [31:0] word_src;
		logic [31:0] word_dst;
		result_t     pending_results[$];
		int          errors;

		function new();
			next_index = WORD_NONE;
			csum_acc = '0;
			buf_avail = '0;
			word_len = '0;
			word_frag = '0;
			word_ttl = '0;
			word_src = '0;
			word_dst = '0;
			errors = 0;
		endfunction

		function void add_half(logic [15:0] half);
			logic [17:0] s;
			s = {1'b0, csum_acc} + {2'b00, half};
			csum_acc = {1'b0, s[15:0]} + {15'd0, s[17:16]};
		endfunction

		function void push_bare(status_t code);
			result_t r;
			r = '0;
			r.status = code;
			pending_results.push_back(r);
		endfunction

		function void push_decoded(status_t code);
			result_t r;
			r.status = code;
			r.header_words = word_len[27:24];
			r.dscp_ecn = word_len[23:16];
			r.total_length = word_len[15:0];
			r.fragment_id = word_frag[31:16];
			r.fragment_flags = word_frag[15:13];
			r.fragment_offset = word_frag[12:0];
			r.time_to_live = word_ttl[31:24];
			r.protocol_number = word_ttl[23:16];
			r.stored_checksum = word_ttl[15:0];
			r.source_address = word_src;
			r.dest_address = word_dst;
			pending_results.push_back(r);
		endfunction

		function void note_header_word(logic [31:0] w, logic first, logic [15:0] nbytes);
			logic [3:0]  ihl;
			logic [15:0] len;
			int          need;
			if (first) begin
				next_index = WORD_NONE;
				csum_acc = '0;
				if (nbytes < MIN_BUFFER_BYTES) begin
					push_bare(STATUS_OVERFLOW);
					return;
				end
				if (w[31:28] != IP_VERSION) begin
					push_bare(STATUS_BAD_VERSION);
					return;
				end
				buf_avail = nbytes;
				word_len = w;
				add_half(w[31:16]);
				add_half(w[15:0]);
				next_index = WORD_FLAGS;
				return;
			end
			if (next_index == WORD_NONE)
				return;
			case (next_index)
				WORD_FLAGS: word_frag = w;
				WORD_TTL:   word_ttl = w;
				WORD_SRC:   word_src = w;
				WORD_DST:   word_dst = w;
				default:    ;
			endcase
			add_half(w[31:16]);
			if (next_index != WORD_TTL)
				add_half(w[15:0]);
			ihl = word_len[27:24];
			len = word_len[15:0];
			if (next_index == WORD_DST &&
					(len > buf_avail || ({12'd0, ihl} << 2) > len || ihl < MIN_IHL)) begin
				push_decoded(STATUS_OVERFLOW);
				next_index = WORD_NONE;
				return;
			end
			need = (ihl < MIN_IHL) ? int'(MIN_IHL) : int'(ihl);
			if (int'(next_index) + 1 >= need && next_index >= WORD_DST) begin
				push_decoded((~csum_acc[15:0] != word_ttl[15:0]) ?
					STATUS_BAD_CHECKSUM : STATUS_OK);
				next_index = WORD_NONE;
				return;
			end
			next_index = next_index + 4'd1;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("MISMATCH %s: got %h, expected %h", what, got, want);
			errors++;
		endtask

		task compare_field(string what, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report(what, got, want);
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report("result with nothing expected, status", 32'(got.status), '0);
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", 32'(got.status), 32'(want.status));
			compare_field("header_words", 32'(got.header_words), 32'(want.header_words));
			compare_field("dscp_ecn", 32'(got.dscp_ecn), 32'(want.dscp_ecn));
			compare_field("total_length", 32'(got.total_length), 32'(want.total_length));
			compare_field("fragment_id", 32'(got.fragment_id), 32'(want.fragment_id));
			compare_field("fragment_flags", 32'(got.fragment_flags),
				32'(want.fragment_flags));
			compare_field("fragment_offset", 32'(got.fragment_offset),
				32'(want.fragment_offset));
			compare_field("time_to_live", 32'(got.time_to_live), 32'(want.time_to_live));
			compare_field("protocol_number", 32'(got.protocol_number),
				32'(want.protocol_number));
			compare_field("stored_checksum", 32'(got.stored_checksum),
				32'(want.stored_checksum));
			compare_field("source_address", got.source_address, want.source_address);
			compare_field("dest_address", got.dest_address, want.dest_address);
		endtask
	endclass

	logic clk;
	logic arst_n;

	ihpc_in_if  hdr_if ();
	ihpc_out_if res_if ();

	ipv4_header_parser_checker_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr_if),
		.res    (res_if)
	);

	ipv4_result_scoreboard results_sb;
	result_t               observed;
	logic [31:0]           hdr_words[$];
	bit                    idling_on;
	int                    items_sent;
	int                    quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && hdr_if.valid && hdr_if.ready)
			results_sb.note_header_word(hdr_if.header_word, hdr_if.first_word,
				hdr_if.buffer_bytes);
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			observed.status = status_t'(res_if.status);
			observed.header_words = res_if.header_words;
			observed.dscp_ecn = res_if.dscp_ecn;
			observed.total_length = res_if.total_length;
			observed.fragment_id = res_if.fragment_id;
			observed.fragment_flags = res_if.fragment_flags;
			observed.fragment_offset = res_if.fragment_offset;
			observed.time_to_live = res_if.time_to_live;
			observed.protocol_number = res_if.protocol_number;
			observed.stored_checksum = res_if.stored_checksum;
			observed.source_address = res_if.source_address;
			observed.dest_address = res_if.dest_address;
			results_sb.check_result(observed);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (hdr_if.valid && hdr_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("** ipv4_header_parser_checker_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 9) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			res_if.ready <= 1'b1;
		end
	end

	function automatic void seal_header();
		logic [31:0] acc;
		acc = '0;
		hdr_words[2][15:0] = '0;
		foreach (hdr_words[i])
			acc = acc + hdr_words[i][31:16] + hdr_words[i][15:0];
		while (acc[31:16] != 0)
			acc = acc[15:0] + acc[31:16];
		hdr_words[2][15:0] = ~acc[15:0];
	endfunction

	function automatic void build_header(logic [3:0] ver, logic [3:0] ihl, logic [15:0] len);
		int n;
		n = (ihl < MIN_IHL) ? int'(MIN_IHL) : int'(ihl);
		hdr_words.delete();
		hdr_words.push_back({ver, ihl, 8'($urandom), len});
		for (int i = 1; i < n; i++)
			hdr_words.push_back($urandom);
		seal_header();
	endfunction

	task automatic send_word(logic [31:0] w, logic first, logic [15:0] nbytes);
		hdr_if.valid <= 1'b1;
		hdr_if.header_word <= w;
		hdr_if.first_word <= first;
		hdr_if.buffer_bytes <= nbytes;
		do
			@(posedge clk);
		while (!hdr_if.ready);
		@(negedge clk);
		if (idling_on && $urandom_range(0, 7) == 0) begin
			hdr_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
	endtask

	task automatic send_header(int count, logic [15:0] nbytes);
		for (int i = 0; i < count; i++)
			send_word(hdr_words[i], i == 0, (i == 0) ? nbytes : 16'($urandom));
		items_sent += count;
	endtask

	task automatic send_random_header();
		int          pick;
		int          ihl;
		int          len;
		int          ver;
		logic [15:0] nbytes;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			ihl = $urandom_range(0, 1) ? 5 : $urandom_range(6, 15);
			len = $urandom_range(0, 1) ? $urandom_range(4 * ihl, 1500) :
				$urandom_range(4 * ihl, 65535);
			nbytes = 16'($urandom_range(len, 65535));
			build_header(IP_VERSION, 4'(ihl), 16'(len));
			if ($urandom_range(0, 6) == 0)
				hdr_words[2][15:0] ^= 16'($urandom_range(1, 65535));
			send_header(hdr_words.size(), nbytes);
		end else if (pick < 68) begin
			ihl = $urandom_range(5, 15);
			len = $urandom_range(21, 65535);
			build_header(IP_VERSION, 4'(ihl), 16'(len));
			send_header(hdr_words.size(), 16'($urandom_range(20, len - 1)));
		end else if (pick < 74) begin
			ihl = $urandom_range(5, 15);
			len = $urandom_range(0, 4 * ihl - 1);
			build_header(IP_VERSION, 4'(ihl), 16'(len));
			send_header(hdr_words.size(),
				16'($urandom_range((len > 20) ? len : 20, 65535)));
		end else if (pick < 80) begin
			ihl = $urandom_range(0, 4);
			len = $urandom_range(0, 2000);
			build_header(IP_VERSION, 4'(ihl), 16'(len));
			send_header(hdr_words.size(),
				16'($urandom_range((len > 20) ? len : 20, 65535)));
		end else if (pick < 85) begin
			build_header(IP_VERSION, MIN_IHL, 16'($urandom_range(20, 65535)));
			send_header($urandom_range(0, 1) ? hdr_words.size() : 1,
				16'($urandom_range(0, int'(MIN_BUFFER_BYTES) - 1)));
		end else if (pick < 90) begin
			ver = $urandom_range(0, 14);
			if (ver >= int'(IP_VERSION))
				ver++;
			build_header(4'(ver), 4'($urandom_range(0, 15)), 16'($urandom));
			send_header($urandom_range(0, 1) ? hdr_words.size() : 1,
				16'($urandom_range(20, 65535)));
		end else if (pick < 95) begin
			ihl = $urandom_range(5, 8);
			build_header(IP_VERSION, 4'(ihl), 16'($urandom_range(4 * ihl, 65535)));
			send_header($urandom_range(1, hdr_words.size() - 1), 16'hFFFF);
		end else if (pick < 98) begin
			send_word($urandom, 1'b0, 16'($urandom));
			items_sent++;
		end else begin
			send_word($urandom, 1'b1, 16'($urandom));
			items_sent++;
		end
	endtask

	initial begin
		results_sb = new();
		idling_on = 1'b1;
		items_sent = 0;
		arst_n = 1'b0;
		hdr_if.valid = 1'b0;
		hdr_if.header_word = '0;
		hdr_if.first_word = 1'b0;
		hdr_if.buffer_bytes = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(32'h4500_0014, 1'b1, MIN_BUFFER_BYTES - 16'd1);
		send_word(32'hF5FF_FFFF, 1'b1, 16'hFFFF);
		send_word(32'hFFFF_FFFF, 1'b0, 16'hFFFF);
		build_header(IP_VERSION, MIN_IHL, 16'd20);
		hdr_words[0][23:16] = 8'hFF;
		hdr_words[1] = 32'hFFFF_FFFF;
		hdr_words[2][31:16] = 16'hFF00;
		hdr_words[3] = 32'hFFFF_FFFF;
		hdr_words[4] = 32'h0000_0000;
		seal_header();
		send_header(5, 16'd20);
		build_header(IP_VERSION, MIN_IHL, 16'd100);
		send_header(5, 16'd99);
		build_header(IP_VERSION, 4'd4, 16'd40);
		send_header(5, 16'd40);
		build_header(IP_VERSION, 4'd6, 16'd200);
		send_header(2, 16'd200);
		build_header(IP_VERSION, MIN_IHL, 16'hFFFF);
		hdr_words[2][15:0] ^= 16'h8001;
		send_header(5, 16'hFFFF);

		while (items_sent < TARGET_WORDS) begin
			if (items_sent >= QUIET_WORDS)
				idling_on = 1'b0;
			else if ($urandom_range(0, 29) == 0)
				idling_on = ($urandom_range(0, 3) != 0);
			send_random_header();
		end
		hdr_if.valid <= 1'b0;

		while (results_sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (results_sb.errors == 0)
			$display("** ipv4_header_parser_checker_core: PASSED **");
		else
			$display("** ipv4_header_parser_checker_core: FAILED **");
		$finish;
	end

endmodule
